// ===== hdl/lpd_pkg.sv =====
// Package for the length-prefix deframer: parse phases, frame constants
// and the result record passed between the parser and the output stage.
// No dependencies.
`default_nettype none
package lpd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 31;
  localparam int unsigned ShortW  = 15;

  // Parse phase of the incoming byte stream
  typedef enum logic [2:0] {
    PH_HDR_LO  = 3'd0,
    PH_HDR_HI  = 3'd1,
    PH_TAIL_LO = 3'd2,
    PH_TAIL_HI = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  // One result item
  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic             end_of_message;
    logic             empty_message;
  } lpd_result_t;

endpackage
`default_nettype wire

// ===== hdl/length_prefix_deframer.sv =====
// A result is offered in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; the single output register refills in the
// cycle its result is taken, so input stalls only while the output stalls.
// Reset (rst_n low, synchronous): parser returns to the header low byte and
// the output register empties.
`default_nettype none
module length_prefix_deframer (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_tvalid,
  output logic                        in_tready,
  input  wire  [lpd_pkg::ByteW-1:0]   in_tdata,   // [7:0] stream_byte
  output logic                        out_tvalid,
  input  wire                         out_tready,
  output logic [lpd_pkg::ByteW-1:0]   out_tdata,  // [7:0] payload_byte
  output logic                        out_tlast,  // end_of_message
  output logic                        out_tuser   // [0] empty_message
);

  logic                 take;
  logic                 res_valid;
  logic                 can_take;
  lpd_pkg::lpd_result_t res;
  lpd_pkg::lpd_result_t out_res;

  assign in_tready = can_take;
  assign take      = in_tvalid && can_take;

  lpd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .byte_in   (in_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  lpd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .can_take  (can_take),
    .out_valid (out_tvalid),
    .out_res   (out_res),
    .out_ready (out_tready)
  );

  assign out_tdata = out_res.payload_byte;
  assign out_tlast = out_res.end_of_message;
  assign out_tuser = out_res.empty_message;

endmodule
`default_nettype wire

// ===== hdl/lpd_parser.sv =====
// Header/tail parser and payload counter of the length-prefix deframer.
// Updates its state on each accepted byte and offers at most one result.
// Depends on lpd_pkg.
`default_nettype none
module lpd_parser (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          take,      // byte accepted this cycle
  input  wire [lpd_pkg::ByteW-1:0]     byte_in,
  output logic                         res_valid,
  output lpd_pkg::lpd_result_t         res
);

  lpd_pkg::phase_t              phase_r, phase_nxt;
  logic [lpd_pkg::ShortW-1:0]   hdr_r, hdr_nxt;
  logic [lpd_pkg::ByteW-1:0]    tail_lo_r, tail_lo_nxt;
  logic [lpd_pkg::LenW-1:0]     remain_r, remain_nxt;

  logic [lpd_pkg::LenW-1:0]     short_len;
  logic [lpd_pkg::LenW-1:0]     long_len;
  logic                         last_byte;

  // Lengths formed from the byte completing each header form
  assign short_len = {{(lpd_pkg::LenW-lpd_pkg::ShortW){1'b0}}, byte_in[6:0], hdr_r[7:0]};
  assign long_len  = {byte_in, tail_lo_r, hdr_r};
  assign last_byte = (remain_r == lpd_pkg::LenW'(1));

  // Next state
  always_comb begin
    phase_nxt   = phase_r;
    hdr_nxt     = hdr_r;
    tail_lo_nxt = tail_lo_r;
    remain_nxt  = remain_r;
    if (take) begin
      case (phase_r)
        lpd_pkg::PH_HDR_HI: begin
          hdr_nxt = {byte_in[6:0], hdr_r[7:0]};
          if (byte_in[7]) begin
            phase_nxt = lpd_pkg::PH_TAIL_LO;
          end else begin
            remain_nxt = short_len;
            phase_nxt  = (short_len == '0) ? lpd_pkg::PH_HDR_LO : lpd_pkg::PH_PAYLOAD;
          end
        end
        lpd_pkg::PH_TAIL_LO: begin
          tail_lo_nxt = byte_in;
          phase_nxt   = lpd_pkg::PH_TAIL_HI;
        end
        lpd_pkg::PH_TAIL_HI: begin
          remain_nxt = long_len;
          phase_nxt  = (long_len == '0) ? lpd_pkg::PH_HDR_LO : lpd_pkg::PH_PAYLOAD;
        end
        lpd_pkg::PH_PAYLOAD: begin
          remain_nxt = remain_r - lpd_pkg::LenW'(1);
          if (last_byte) begin
            phase_nxt = lpd_pkg::PH_HDR_LO;
          end
        end
        default: begin
          // header low byte, also taken for unused phase codes
          hdr_nxt   = {hdr_r[14:8], byte_in};
          phase_nxt = lpd_pkg::PH_HDR_HI;
        end
      endcase
    end
  end

  // Result offered for the accepted byte
  always_comb begin
    res_valid          = 1'b0;
    res.payload_byte   = '0;
    res.end_of_message = 1'b0;
    res.empty_message  = 1'b0;
    case (phase_r)
      lpd_pkg::PH_HDR_HI: begin
        if (!byte_in[7] && short_len == '0) begin
          res_valid          = take;
          res.end_of_message = 1'b1;
          res.empty_message  = 1'b1;
        end
      end
      lpd_pkg::PH_TAIL_HI: begin
        if (long_len == '0) begin
          res_valid          = take;
          res.end_of_message = 1'b1;
          res.empty_message  = 1'b1;
        end
      end
      lpd_pkg::PH_PAYLOAD: begin
        res_valid          = take;
        res.payload_byte   = byte_in;
        res.end_of_message = last_byte;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // Hold parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= lpd_pkg::PH_HDR_LO;
      hdr_r     <= '0;
      tail_lo_r <= '0;
      remain_r  <= '0;
    end else begin
      phase_r   <= phase_nxt;
      hdr_r     <= hdr_nxt;
      tail_lo_r <= tail_lo_nxt;
      remain_r  <= remain_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/lpd_out_reg.sv =====
// Output register of the length-prefix deframer: one result held for the
// downstream side, refilled in the same cycle it is taken.
// Depends on lpd_pkg.
`default_nettype none
module lpd_out_reg (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   res_valid,
  input  lpd_pkg::lpd_result_t  res,
  output logic                  can_take,   // room for a result this cycle
  output logic                  out_valid,
  output lpd_pkg::lpd_result_t  out_res,
  input  wire                   out_ready
);

  logic                 valid_r, valid_nxt;
  lpd_pkg::lpd_result_t res_r;

  assign can_take  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  // Drop the held result once taken, load a new one when offered
  always_comb begin
    valid_nxt = valid_r;
    if (can_take) begin
      valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (can_take && res_valid) begin
      res_r <= res;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/lpd_checker.sv =====
// Port-level checks for the length-prefix deframer, bound to the top level.
// Depends on length_prefix_deframer ports only.
`default_nettype none
module lpd_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_tready,
  input wire       out_tvalid,
  input wire       out_tready,
  input wire [7:0] out_tdata,
  input wire       out_tlast,
  input wire       out_tuser
);

  // Output empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled result changed");

  // Empty marker always closes a message and carries no byte
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && out_tdata == 8'd0)
    else $error("malformed empty marker");

  // Input is open whenever the output register is free or draining
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input stalled without output backpressure");

endmodule

bind length_prefix_deframer lpd_checker u_lpd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
`default_nettype wire

// ===== tb/length_prefix_deframer_test.sv =====
// Self-checking test for length_prefix_deframer: drives a byte stream of
// length-prefixed messages, predicts every output request and compares them.
// Depends on lpd_pkg and length_prefix_deframer.
`default_nettype none
module length_prefix_deframer_test;

  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned DrainCycles   = 10;
  localparam int unsigned LongHeadBytes = 40;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [lpd_pkg::ByteW-1:0]      in_tdata = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [lpd_pkg::ByteW-1:0]      out_tdata;
  logic                           out_tlast;
  logic                           out_tuser;

  // Stream bytes waiting to be offered, and results still owed by the block
  logic [lpd_pkg::ByteW-1:0]      pending_bytes[$];
  lpd_pkg::lpd_result_t           predicted_results[$];

  // Traffic shaping, written at the falling edge only
  int unsigned                    send_idle_pct = 0;
  int unsigned                    recv_stall_pct = 0;
  logic                           hold_off_req = 1'b0;
  logic                           hold_off = 1'b0;

  int unsigned                    mismatches = 0;
  int unsigned                    cycle_count = 0;

  // Shadow parser state
  lpd_pkg::phase_t                parse_phase = lpd_pkg::PH_HDR_LO;
  logic [15:0]                    hdr_word = '0;
  logic [7:0]                     tail_lo = '0;
  logic [lpd_pkg::LenW-1:0]       remaining = '0;

  length_prefix_deframer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Enter payload with the decoded length; a zero length gives the empty marker
  task automatic open_payload(input logic [lpd_pkg::LenW-1:0] len);
    lpd_pkg::lpd_result_t marker;
    remaining = len;
    if (len == '0) begin
      marker.payload_byte   = '0;
      marker.end_of_message = 1'b1;
      marker.empty_message  = 1'b1;
      predicted_results.push_back(marker);
      parse_phase = lpd_pkg::PH_HDR_LO;
    end else begin
      parse_phase = lpd_pkg::PH_PAYLOAD;
    end
  endtask

  // Advance the shadow parser by one accepted stream byte
  task automatic deframe_byte(input logic [lpd_pkg::ByteW-1:0] b);
    lpd_pkg::lpd_result_t res;
    case (parse_phase)
      lpd_pkg::PH_HDR_HI: begin
        hdr_word[15:8] = b;
        if (hdr_word[15]) parse_phase = lpd_pkg::PH_TAIL_LO;
        else open_payload({16'd0, hdr_word[14:0]});
      end
      lpd_pkg::PH_TAIL_LO: begin
        tail_lo     = b;
        parse_phase = lpd_pkg::PH_TAIL_HI;
      end
      lpd_pkg::PH_TAIL_HI: begin
        open_payload({b, tail_lo, hdr_word[14:0]});
      end
      lpd_pkg::PH_PAYLOAD: begin
        remaining          = remaining - lpd_pkg::LenW'(1);
        res.payload_byte   = b;
        res.end_of_message = (remaining == '0);
        res.empty_message  = 1'b0;
        predicted_results.push_back(res);
        if (remaining == '0) parse_phase = lpd_pkg::PH_HDR_LO;
      end
      default: begin
        hdr_word    = {8'h00, b};
        parse_phase = lpd_pkg::PH_HDR_HI;
      end
    endcase
  endtask

  // Queue one message: header, tail word if long form, random payload
  task automatic push_message(input logic [15:0] hdr, input logic [15:0] tail);
    int unsigned count;
    pending_bytes.push_back(hdr[7:0]);
    pending_bytes.push_back(hdr[15:8]);
    if (hdr[15]) begin
      pending_bytes.push_back(tail[7:0]);
      pending_bytes.push_back(tail[15:8]);
      count = 32'({tail, hdr[14:0]});
    end else begin
      count = 32'(hdr[14:0]);
    end
    repeat (count) pending_bytes.push_back(lpd_pkg::ByteW'($urandom_range(255)));
  endtask

  // Mostly short messages, some empty, a few past one byte of length
  task automatic push_random_message();
    int unsigned pick;
    logic [14:0] len;
    pick = $urandom_range(99);
    if (pick < 12) len = '0;
    else if (pick < 70) len = 15'($urandom_range(16, 1));
    else if (pick < 92) len = 15'($urandom_range(64, 17));
    else len = 15'($urandom_range(300, 200));
    push_message({($urandom_range(3) == 0), len}, 16'h0000);
  endtask

  // Hold until the sender has nothing left and every result has arrived
  task automatic wait_drained();
    wait (pending_bytes.size() == 0 && !in_tvalid);
    wait (predicted_results.size() == 0);
    @(negedge clk);
  endtask

  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input int unsigned nbytes);
    int unsigned start;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    start = pending_bytes.size();
    while (pending_bytes.size() - start < nbytes) push_random_message();
    wait_drained();
  endtask

  // Drive input requests; hold each byte until it is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) deframe_byte(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_bytes.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Check each output request against the oldest prediction
  always @(posedge clk) begin
    lpd_pkg::lpd_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (predicted_results.size() == 0) begin
          $error("unexpected result: payload_byte %0h end_of_message %0b empty_message %0b",
                 out_tdata, out_tlast, out_tuser);
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          if (out_tdata !== want.payload_byte) begin
            $error("payload_byte: expected %0h, got %0h", want.payload_byte, out_tdata);
            mismatches++;
          end
          if (out_tlast !== want.end_of_message) begin
            $error("end_of_message: expected %0b, got %0b", want.end_of_message, out_tlast);
            mismatches++;
          end
          if (out_tuser !== want.empty_message) begin
            $error("empty_message: expected %0b, got %0b", want.empty_message, out_tuser);
            mismatches++;
          end
        end
      end
      out_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver stall so the output register fills and input backs up
  initial begin : receiver_hold_off
    wait (hold_off_req);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (HoldOffCycles) @(negedge clk);
    hold_off = 1'b0;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    logic [lpd_pkg::ByteW-1:0] intro_bytes[23];
    logic [lpd_pkg::ByteW-1:0] long_head[4];
    // empty short, empty long form, single zero byte, single 0xff,
    // long form of two bytes, short form of three bytes
    intro_bytes = '{8'h00, 8'h00,
                    8'h00, 8'h80, 8'h00, 8'h00,
                    8'h01, 8'h00, 8'h00,
                    8'h01, 8'h00, 8'hff,
                    8'h02, 8'h80, 8'h00, 8'h00, 8'ha5, 8'h5a,
                    8'h03, 8'h00, 8'hff, 8'h80, 8'h7f};
    // long-form header with tail word 1: length 0x8000
    long_head = '{8'h00, 8'h80, 8'h01, 8'h00};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (intro_bytes[i]) pending_bytes.push_back(intro_bytes[i]);
    wait_drained();

    // Back-to-back traffic with a long receiver stall
    hold_off_req = 1'b1;
    run_phase(0, 0, 300);

    run_phase(84, 0, 300);
    run_phase(0, 84, 300);
    run_phase(18, 18, 300);
    run_phase(0, 0, 60);

    // Long-form message whose tail word carries the length into bit 15;
    // only its head is sent, so none of these bytes closes the message
    foreach (long_head[i]) pending_bytes.push_back(long_head[i]);
    repeat (LongHeadBytes) pending_bytes.push_back(lpd_pkg::ByteW'($urandom_range(255)));
    wait_drained();

    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && predicted_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
